[design/oale_pkg.sv]
// Shared types and codes for the ordered array list engine.
package oale_pkg;

   // Request modes.
   typedef enum logic [1:0] {
      MODE_GET    = 2'd0,
      MODE_LOCATE = 2'd1,
      MODE_INSERT = 2'd2,
      MODE_DELETE = 2'd3
   } mode_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // Kinds of walk over the stored entries.
   typedef enum logic [1:0] {
      WALK_SCAN = 2'd0,
      WALK_UP   = 2'd1,
      WALK_DOWN = 2'd2
   } walk_kind_type;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_GET_WAIT,
      ST_DEL_WAIT,
      ST_SCAN,
      ST_SHIFT_UP,
      ST_SHIFT_DOWN,
      ST_PUT,
      ST_DONE
   } state_type;

   // Request transaction payload.
   typedef struct packed {
      mode_type    mode;
      logic [6:0]  position;
      logic [31:0] value;
   } req_type;

   // Result transaction payload.
   typedef struct packed {
      logic [31:0] read_word;
      logic [6:0]  found_position;
      logic [6:0]  entry_count;
      status_type  status;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic          load_req;
      logic          rd_pos;
      logic          cap_word;
      logic          set_status;
      status_type    status_code;
      logic          set_found;
      logic          init_walk;
      walk_kind_type walk_kind;
      logic          walk_step;
      logic          put;
      logic          cnt_inc;
      logic          cnt_dec;
      logic          rsp_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      mode_type mode;
      logic     get_ok;
      logic     ins_ok;
      logic     full;
      logic     append;
      logic     del_last;
      logic     walk_busy;
      logic     match;
      logic     rsp_free;
   } stat_type;

endpackage

[design/oale_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module oale_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/oale_datapath.sv]
// Datapath: request registers, entry memory, walk pointers, count and result register.
module oale_datapath #(
   parameter int CAPACITY   = 64,
   parameter int WORD_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  oale_pkg::cmd_type cmd,
   output oale_pkg::stat_type stat,
   input  oale_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output oale_pkg::rsp_type rsp_payload
);
   import oale_pkg::*;

   localparam int IW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = ((CW > 7) ? CW : 7) + 1;

   mode_type        mode_ff;
   logic [6:0]      pos_ff;
   logic [WORD_WIDTH-1:0] val_ff;
   logic [CW-1:0]   count_ff, count_in;
   logic [WORD_WIDTH-1:0] res_word_ff;
   logic [6:0]      res_found_ff;
   status_type      res_status_ff;

   walk_kind_type   walk_kind_ff, walk_kind_in;
   logic [IW-1:0]   idx_ff, idx_in;
   logic [IW-1:0]   end_ff, end_in;
   logic            issue_ff, issue_in;
   logic            pend_ff, pend_in;
   logic [IW-1:0]   pend_idx_ff, pend_idx_in;

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff;

   logic [CMPW-1:0] pos_ext, cnt_ext, found_ext;
   logic [IW-1:0]   pos0, cnt_m1, walk_waddr;
   logic [WORD_WIDTH-1:0] val_w, ram_rd_data, ram_wr_data;
   logic [31:0]     word32;
   logic [IW-1:0]   ram_rd_addr, ram_wr_addr;
   logic            ram_wr_en, walk_wr;

   // Fit the request value to the stored word width.
   if (WORD_WIDTH <= 32) begin : g_val_narrow
      assign val_w = req_payload.value[WORD_WIDTH-1:0];
   end else begin : g_val_wide
      assign val_w = {{(WORD_WIDTH-32){1'b0}}, req_payload.value};
   end

   // Fit the stored word to the 32-bit result field.
   if (WORD_WIDTH >= 32) begin : g_word_wide
      assign word32 = res_word_ff[31:0];
   end else begin : g_word_narrow
      assign word32 = {{(32-WORD_WIDTH){1'b0}}, res_word_ff};
   end

   // Position and count arithmetic on a common width.
   assign pos_ext   = CMPW'(pos_ff);
   assign cnt_ext   = CMPW'(count_ff);
   assign pos0      = IW'(pos_ext - CMPW'(1));
   assign cnt_m1    = IW'(cnt_ext - CMPW'(1));
   assign found_ext = CMPW'(pend_idx_ff) + CMPW'(1);

   // Memory port steering: single reads by position, walk moves, and the insert write.
   assign walk_wr     = cmd.walk_step && pend_ff && (walk_kind_ff != WALK_SCAN);
   assign walk_waddr  = (walk_kind_ff == WALK_UP) ? (pend_idx_ff + IW'(1))
                                                  : (pend_idx_ff - IW'(1));
   assign ram_rd_addr = cmd.rd_pos ? pos0 : idx_ff;
   assign ram_wr_en   = cmd.put || walk_wr;
   assign ram_wr_addr = cmd.put ? pos0 : walk_waddr;
   assign ram_wr_data = cmd.put ? val_ff : ram_rd_data;

   oale_ram #(
      .WIDTH (WORD_WIDTH),
      .DEPTH (CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Walk pointer: one read issued per step, the data lands in the next cycle.
   always_comb begin
      walk_kind_in = walk_kind_ff;
      idx_in       = idx_ff;
      end_in       = end_ff;
      issue_in     = issue_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      if (cmd.init_walk) begin
         walk_kind_in = cmd.walk_kind;
         pend_in      = 1'b0;
         case (cmd.walk_kind)
            WALK_SCAN: begin
               idx_in   = '0;
               end_in   = cnt_m1;
               issue_in = (count_ff != '0);
            end
            WALK_UP: begin
               idx_in   = cnt_m1;
               end_in   = pos0;
               issue_in = 1'b1;
            end
            WALK_DOWN: begin
               idx_in   = pos0 + IW'(1);
               end_in   = cnt_m1;
               issue_in = 1'b1;
            end
            default: begin
               issue_in = 1'b0;
            end
         endcase
      end else if (cmd.walk_step) begin
         pend_in     = issue_ff;
         pend_idx_in = idx_ff;
         if (issue_ff) begin
            if (idx_ff == end_ff) begin
               issue_in = 1'b0;
            end else if (walk_kind_ff == WALK_UP) begin
               idx_in = idx_ff - IW'(1);
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
      end
   end

   // Walk control flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         issue_ff <= issue_in;
         pend_ff  <= pend_in;
      end
   end

   // Walk pointers.
   always_ff @(posedge clock) begin
      walk_kind_ff <= walk_kind_in;
      idx_ff       <= idx_in;
      end_ff       <= end_in;
      pend_idx_ff  <= pend_idx_in;
   end

   // Entry count.
   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Request capture and the result being built.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         mode_ff       <= req_payload.mode;
         pos_ff        <= req_payload.position;
         val_ff        <= val_w;
         res_word_ff   <= '0;
         res_found_ff  <= '0;
         res_status_ff <= STATUS_OK;
      end
      if (cmd.set_status) begin
         res_status_ff <= cmd.status_code;
      end
      if (cmd.cap_word) begin
         res_word_ff <= ram_rd_data;
      end
      if (cmd.set_found) begin
         res_found_ff <= found_ext[6:0];
      end
   end

   // Output register for the result transaction.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_data_ff.read_word      <= word32;
         rsp_data_ff.found_position <= res_found_ff;
         rsp_data_ff.entry_count    <= cnt_ext[6:0];
         rsp_data_ff.status         <= res_status_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // Status toward the controller.
   always_comb begin
      stat.mode      = mode_ff;
      stat.get_ok    = (pos_ext != '0) && (pos_ext <= cnt_ext);
      stat.ins_ok    = (pos_ext != '0) && (pos_ext <= (cnt_ext + CMPW'(1)));
      stat.full      = (count_ff == CW'(CAPACITY));
      stat.append    = (pos_ext == (cnt_ext + CMPW'(1)));
      stat.del_last  = (pos_ext == cnt_ext);
      stat.walk_busy = issue_ff || pend_ff;
      stat.match     = pend_ff && (walk_kind_ff == WALK_SCAN) && (ram_rd_data == val_ff);
      stat.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

endmodule

[design/oale_controller.sv]
// Controller state machine that sequences each request through the datapath.
module oale_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output oale_pkg::cmd_type  cmd,
   input  oale_pkg::stat_type stat
);
   import oale_pkg::*;

   state_type state_ff, state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (stat.mode)
               MODE_GET:    state_in = stat.get_ok ? ST_GET_WAIT : ST_DONE;
               MODE_LOCATE: state_in = ST_SCAN;
               MODE_INSERT: begin
                  if (stat.full || !stat.ins_ok) begin
                     state_in = ST_DONE;
                  end else if (stat.append) begin
                     state_in = ST_PUT;
                  end else begin
                     state_in = ST_SHIFT_UP;
                  end
               end
               MODE_DELETE: state_in = stat.get_ok ? ST_DEL_WAIT : ST_DONE;
               default:     state_in = ST_DONE;
            endcase
         end
         ST_GET_WAIT: state_in = ST_DONE;
         ST_DEL_WAIT: state_in = stat.del_last ? ST_DONE : ST_SHIFT_DOWN;
         ST_SCAN: begin
            if (stat.match || !stat.walk_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_SHIFT_UP: begin
            if (!stat.walk_busy) begin
               state_in = ST_PUT;
            end
         end
         ST_SHIFT_DOWN: begin
            if (!stat.walk_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_PUT: state_in = ST_DONE;
         ST_DONE: begin
            if (stat.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands for each state.
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         ST_DECODE: begin
            unique case (stat.mode)
               MODE_GET: begin
                  if (stat.get_ok) begin
                     cmd.rd_pos = 1'b1;
                  end else begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = STATUS_RANGE;
                  end
               end
               MODE_LOCATE: begin
                  cmd.init_walk = 1'b1;
                  cmd.walk_kind = WALK_SCAN;
               end
               MODE_INSERT: begin
                  if (stat.full) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = STATUS_FULL;
                  end else if (!stat.ins_ok) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = STATUS_RANGE;
                  end else if (!stat.append) begin
                     cmd.init_walk = 1'b1;
                     cmd.walk_kind = WALK_UP;
                  end
               end
               MODE_DELETE: begin
                  if (stat.get_ok) begin
                     cmd.rd_pos = 1'b1;
                  end else begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = STATUS_RANGE;
                  end
               end
               default: begin
                  cmd.set_status  = 1'b1;
                  cmd.status_code = STATUS_RANGE;
               end
            endcase
         end
         ST_GET_WAIT: begin
            cmd.cap_word = 1'b1;
         end
         ST_DEL_WAIT: begin
            cmd.cap_word = 1'b1;
            if (stat.del_last) begin
               cmd.cnt_dec = 1'b1;
            end else begin
               cmd.init_walk = 1'b1;
               cmd.walk_kind = WALK_DOWN;
            end
         end
         ST_SCAN: begin
            cmd.walk_step = 1'b1;
            cmd.set_found = stat.match;
         end
         ST_SHIFT_UP: begin
            cmd.walk_step = 1'b1;
         end
         ST_SHIFT_DOWN: begin
            cmd.walk_step = 1'b1;
            cmd.cnt_dec   = !stat.walk_busy;
         end
         ST_PUT: begin
            cmd.put     = 1'b1;
            cmd.cnt_inc = 1'b1;
         end
         ST_DONE: begin
            cmd.rsp_load = stat.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[design/ordered_array_list_engine.sv]
// Top level of the ordered array list engine: controller, datapath and checks.
//
//   Channel | Ports                             | Carries
//   --------+-----------------------------------+-----------------------------------
//   request | req_valid, req_ready, req_payload | mode, position, value
//   result  | rsp_valid, rsp_ready, rsp_payload | read_word, found_position,
//           |                                   | entry_count, status
//
// One request is worked at a time; the entry memory has one read and one write
// port, and every walk reads one entry per cycle through it; shifts move that entry.
// Locate stops at the first match.
// Reset clears the entry count and all control state; the memory is not cleared.
// A result waits in the output register while the next request is accepted.
module ordered_array_list_engine #(
   parameter int CAPACITY   = 64,
   parameter int WORD_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  oale_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output oale_pkg::rsp_type rsp_payload
);
   import oale_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   oale_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   oale_datapath #(
      .CAPACITY   (CAPACITY),
      .WORD_WIDTH (WORD_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // After a request transaction the block is busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while the previous one was still decoding");

   // A result is loaded only when the output register can take it.
   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> stat.rsp_free)
      else $error("result loaded over an untaken result");

   // Loading a result shows it and frees the request side.
   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> (rsp_valid && req_ready))
      else $error("loaded result not presented or block not idle");

   // An insert write happens only on an insert that is in range and not full.
   assert property (@(posedge clock) disable iff (reset)
      cmd.put |-> (stat.ins_ok && !stat.full && (stat.mode == MODE_INSERT)))
      else $error("insert write on an invalid request");

endmodule
